FILE: rtl/core/strongly_connected_components_core_assert.svh
// Assertion macros shared by the strongly connected components RTL.
`ifndef STRONGLY_CONNECTED_COMPONENTS_CORE_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define SCC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at the same edge.
`define SCC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/scc_pkg.sv
// Shared opcodes, register indexes and field widths for the SCC core.
package scc_pkg;

   localparam int VERTEX_FIELD_W = 6;
   localparam int DST_FIELD_W    = 7;
   localparam int COUNT_FIELD_W  = 7;
   localparam int OP_FIELD_W     = 2;

   // Request opcodes carried in req_tuser
   localparam logic [OP_FIELD_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OP_FIELD_W-1:0] OP_RUN      = 2'd1;
   localparam logic [OP_FIELD_W-1:0] OP_CLEAR    = 2'd2;

   // Register index decoded from csr_paddr[2]
   localparam logic CSR_VERTEX_COUNT = 1'b0;

   // Search sequencer states
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD      = 9'b000000010,
      ST_ROOT     = 9'b000000100,
      ST_SCAN     = 9'b000001000,
      ST_CHECK    = 9'b000010000,
      ST_POP      = 9'b000100000,
      ST_POP_WAIT = 9'b001000000,
      ST_RET      = 9'b010000000,
      ST_RET_WAIT = 9'b100000000
   } state_type;

endpackage

FILE: rtl/core/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/strongly_connected_components_core.sv
// Top level: Tarjan strongly connected components search over a RAM adjacency matrix.
//
//  channel | direction | handshake            | content
//  req     | in        | tvalid/tready        | tuser op, tdata src/dst
//  rsp     | out       | tvalid/tready/tlast  | tdata vertex/component, tuser end of component
//  csr     | in/out    | psel/penable/pready  | vertex_count at offset 0
//
// Edge add: adjacency row read, then write back. Clear and unused ops complete in the idle state.
// Run: steps over the root positions, scans each edge and checks the index of each on-stack neighbor;
// each vertex then takes a last scan, a return and a parent reload, and its pop; tlast closes the run.
// Reset clears control state and all row valid bits; clear drops the row valid bits at once.
// A stalled rsp channel holds the search at the next emitted vertex.
`include "strongly_connected_components_core_assert.svh"

module strongly_connected_components_core #(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] src_vertex, [12:6] dst_vertex, [15:13] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] vertex, [11:6] component, [15:12] zero
   output logic        rsp_tuser,   // [0] last_in_component
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import scc_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);

   typedef struct packed {
      logic [VW-1:0] parent;
      logic [VW-1:0] below;
      logic [VW:0]   pos;
      logic [VW-1:0] low;
      logic [VW-1:0] idx;
   } vinfo_type;

   localparam int VI_W = $bits(vinfo_type);

   // ---------------- registers ----------------
   state_type            state_ff, state_in;
   logic [COUNT_FIELD_W-1:0] vc_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] on_stack_ff, on_stack_in;
   logic [VW-1:0]        add_src_ff, add_src_in;
   logic [MAX_VERTICES-1:0] add_bit_ff, add_bit_in;
   logic                 row_ok_ff, row_ok_in;
   logic [VW:0]          root_ff, root_in;
   logic [VW:0]          next_index_ff, next_index_in;
   logic [VW-1:0]        comp_ff, comp_in;
   logic [VW:0]          call_depth_ff, call_depth_in;
   logic [VW-1:0]        scc_top_ff, scc_top_in;
   logic [VW-1:0]        cur_v_ff, cur_v_in;
   vinfo_type            cur_ff, cur_in;
   logic [VW-1:0]        child_low_ff, child_low_in;

   // result staging: pend holds the newest vertex until its last flag is known
   logic                 pend_valid_ff;
   logic [VW-1:0]        pend_vertex_ff;
   logic [VW-1:0]        pend_comp_ff;
   logic                 pend_lastc_ff;
   logic                 rsp_valid_ff;
   logic [VW-1:0]        rsp_vertex_ff;
   logic [VW-1:0]        rsp_comp_ff;
   logic                 rsp_lastc_ff;
   logic                 rsp_last_ff;

   // ---------------- RAM ports ----------------
   logic                    adj_wr_en, adj_rd_en;
   logic [VW-1:0]           adj_wr_addr, adj_rd_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
   logic                    vi_wr_en, vi_rd_en;
   logic [VW-1:0]           vi_wr_addr, vi_rd_addr;
   vinfo_type               vi_wr_data;
   logic [VI_W-1:0]         vi_rd_raw;
   vinfo_type               vi_rd;

   // ---------------- combinational helpers ----------------
   logic [VW:0]             n_used;
   logic [MAX_VERTICES-1:0] use_mask, pos_mask, cand;
   logic                    has_cand;
   logic [VW-1:0]           w_sel;
   logic [OP_FIELD_W-1:0]   req_op;
   logic [VERTEX_FIELD_W-1:0] req_src;
   logic [DST_FIELD_W-1:0]  req_dst;
   logic                    edge_ok;
   logic                    can_push;
   logic                    emit;
   logic [VW-1:0]           emit_vertex;
   logic                    emit_lastc;
   logic                    flush_go;
   logic                    enter_go;
   logic [VW-1:0]           enter_w;
   logic [VW-1:0]           enter_parent;
   logic                    csr_wr;

   assign req_op  = req_tuser;
   assign req_src = req_tdata[5:0];
   assign req_dst = req_tdata[12:6];

   // vertices in use: count clamped to the array size
   assign n_used = (vc_ff > COUNT_FIELD_W'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
                                                           : vc_ff[VW:0];

   assign edge_ok = ({1'b0, req_src} < COUNT_FIELD_W'(n_used)) &&
                    (req_dst != '0) && (req_dst <= COUNT_FIELD_W'(n_used));

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         use_mask[i] = ((VW+1)'(i) < n_used);
         pos_mask[i] = ((VW+1)'(i) >= cur_ff.pos);
      end
   end

   assign cand     = adj_rd_data & {MAX_VERTICES{row_ok_ff}} & use_mask & pos_mask;
   assign has_cand = |cand;

   // lowest set candidate bit
   always_comb begin
      w_sel = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            w_sel = VW'(i);
         end
      end
   end

   assign can_push = !pend_valid_ff || !rsp_valid_ff || rsp_tready;
   assign vi_rd    = vinfo_type'(vi_rd_raw);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      row_valid_in   = row_valid_ff;
      visited_in     = visited_ff;
      on_stack_in    = on_stack_ff;
      add_src_in     = add_src_ff;
      add_bit_in     = add_bit_ff;
      row_ok_in      = row_ok_ff;
      root_in        = root_ff;
      next_index_in  = next_index_ff;
      comp_in        = comp_ff;
      call_depth_in  = call_depth_ff;
      scc_top_in     = scc_top_ff;
      cur_v_in       = cur_v_ff;
      cur_in         = cur_ff;
      child_low_in   = child_low_ff;
      adj_wr_en      = 1'b0;
      adj_wr_addr    = add_src_ff;
      adj_wr_data    = (row_valid_ff[add_src_ff] ? adj_rd_data : '0) | add_bit_ff;
      adj_rd_en      = 1'b0;
      adj_rd_addr    = '0;
      vi_wr_en       = 1'b0;
      vi_wr_addr     = cur_v_ff;
      vi_wr_data     = cur_ff;
      vi_rd_en       = 1'b0;
      vi_rd_addr     = '0;
      emit           = 1'b0;
      emit_vertex    = scc_top_ff;
      emit_lastc     = 1'b0;
      flush_go       = 1'b0;
      enter_go       = 1'b0;
      enter_w        = '0;
      enter_parent   = cur_v_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pend_valid_ff) begin
               // close the finished run: last result gets tlast
               if (!rsp_valid_ff || rsp_tready) begin
                  flush_go = 1'b1;
               end
            end else if (req_tvalid) begin
               unique case (req_op)
                  OP_ADD_EDGE: begin
                     if (edge_ok) begin
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = req_src[VW-1:0];
                        add_src_in  = req_src[VW-1:0];
                        for (int i = 0; i < MAX_VERTICES; i++) begin
                           add_bit_in[i] = (req_dst == DST_FIELD_W'(i + 1));
                        end
                        state_in = ST_ADD;
                     end
                  end
                  OP_RUN: begin
                     visited_in    = '0;
                     on_stack_in   = '0;
                     next_index_in = '0;
                     comp_in       = '0;
                     call_depth_in = '0;
                     root_in       = '0;
                     state_in      = ST_ROOT;
                  end
                  OP_CLEAR: begin
                     row_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ADD: begin
            adj_wr_en                = 1'b1;
            row_valid_in[add_src_ff] = 1'b1;
            state_in                 = ST_IDLE;
         end

         ST_ROOT: begin
            if (root_ff >= n_used) begin
               state_in = ST_IDLE;
            end else if (visited_ff[root_ff[VW-1:0]]) begin
               root_in = root_ff + 1'b1;
            end else begin
               enter_go = 1'b1;
               enter_w  = root_ff[VW-1:0];
            end
         end

         ST_SCAN: begin
            if (has_cand) begin
               cur_in.pos = (VW+1)'(w_sel) + 1'b1;
               if (w_sel == cur_v_ff) begin
                  // self loop leaves the low link unchanged
               end else if (!visited_ff[w_sel]) begin
                  // descend: save this frame, then enter the neighbor
                  vi_wr_en       = 1'b1;
                  vi_wr_data     = cur_ff;
                  vi_wr_data.pos = (VW+1)'(w_sel) + 1'b1;
                  enter_go       = 1'b1;
                  enter_w        = w_sel;
               end else if (on_stack_ff[w_sel]) begin
                  vi_rd_en   = 1'b1;
                  vi_rd_addr = w_sel;
                  state_in   = ST_CHECK;
               end
            end else begin
               call_depth_in = call_depth_ff - 1'b1;
               state_in      = (cur_ff.low == cur_ff.idx) ? ST_POP : ST_RET;
            end
         end

         ST_CHECK: begin
            if (vi_rd.idx < cur_ff.low) begin
               cur_in.low = vi_rd.idx;
            end
            state_in = ST_SCAN;
         end

         ST_POP: begin
            if (scc_top_ff == cur_v_ff) begin
               if (can_push) begin
                  emit                  = 1'b1;
                  emit_lastc            = 1'b1;
                  on_stack_in[cur_v_ff] = 1'b0;
                  scc_top_in            = cur_ff.below;
                  comp_in               = comp_ff + 1'b1;
                  state_in              = ST_RET;
               end
            end else begin
               vi_rd_en   = 1'b1;
               vi_rd_addr = scc_top_ff;
               state_in   = ST_POP_WAIT;
            end
         end

         ST_POP_WAIT: begin
            if (can_push) begin
               emit                    = 1'b1;
               on_stack_in[scc_top_ff] = 1'b0;
               scc_top_in              = vi_rd.below;
               state_in                = ST_POP;
            end
         end

         ST_RET: begin
            vi_wr_en = 1'b1;
            if (call_depth_ff == '0) begin
               state_in = ST_ROOT;
            end else begin
               vi_rd_en     = 1'b1;
               vi_rd_addr   = cur_ff.parent;
               child_low_in = cur_ff.low;
               state_in     = ST_RET_WAIT;
            end
         end

         ST_RET_WAIT: begin
            cur_v_in = cur_ff.parent;
            cur_in   = vi_rd;
            if (child_low_ff < vi_rd.low) begin
               cur_in.low = child_low_ff;
            end
            adj_rd_en   = 1'b1;
            adj_rd_addr = cur_ff.parent;
            row_ok_in   = row_valid_ff[cur_ff.parent];
            state_in    = ST_SCAN;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // vertex entry shared by roots and descents
      if (enter_go) begin
         visited_in[enter_w]  = 1'b1;
         on_stack_in[enter_w] = 1'b1;
         cur_v_in             = enter_w;
         cur_in.parent        = enter_parent;
         cur_in.below         = scc_top_ff;
         cur_in.pos           = '0;
         cur_in.idx           = next_index_ff[VW-1:0];
         cur_in.low           = next_index_ff[VW-1:0];
         next_index_in        = next_index_ff + 1'b1;
         scc_top_in           = enter_w;
         call_depth_in        = call_depth_ff + 1'b1;
         adj_rd_en            = 1'b1;
         adj_rd_addr          = enter_w;
         row_ok_in            = row_valid_ff[enter_w];
         state_in             = ST_SCAN;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_valid_ff  <= '0;
         visited_ff    <= '0;
         on_stack_ff   <= '0;
         root_ff       <= '0;
         next_index_ff <= '0;
         comp_ff       <= '0;
         call_depth_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         visited_ff    <= visited_in;
         on_stack_ff   <= on_stack_in;
         root_ff       <= root_in;
         next_index_ff <= next_index_in;
         comp_ff       <= comp_in;
         call_depth_ff <= call_depth_in;
         if (emit) begin
            pend_valid_ff <= 1'b1;
         end else if (flush_go) begin
            pend_valid_ff <= 1'b0;
         end
         if ((emit && pend_valid_ff) || flush_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      add_src_ff   <= add_src_in;
      add_bit_ff   <= add_bit_in;
      row_ok_ff    <= row_ok_in;
      scc_top_ff   <= scc_top_in;
      cur_v_ff     <= cur_v_in;
      cur_ff       <= cur_in;
      child_low_ff <= child_low_in;
      if (emit) begin
         pend_vertex_ff <= emit_vertex;
         pend_comp_ff   <= comp_ff;
         pend_lastc_ff  <= emit_lastc;
      end
      if ((emit && pend_valid_ff) || flush_go) begin
         rsp_vertex_ff <= pend_vertex_ff;
         rsp_comp_ff   <= pend_comp_ff;
         rsp_lastc_ff  <= pend_lastc_ff;
         rsp_last_ff   <= flush_go;
      end
   end

   // ---------------- configuration ----------------
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= COUNT_FIELD_W'(64);
      end else if (csr_wr && (csr_paddr[2] == CSR_VERTEX_COUNT)) begin
         vc_ff <= csr_pwdata[COUNT_FIELD_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_VERTEX_COUNT) ? {25'd0, vc_ff} : 32'd0;

   // ---------------- memories ----------------
   scc_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   scc_ram #(
      .WIDTH (VI_W),
      .DEPTH (MAX_VERTICES)
   ) u_vinfo_ram (
      .clock   (clock),
      .wr_en   (vi_wr_en),
      .wr_addr (vi_wr_addr),
      .wr_data (vi_wr_data),
      .rd_en   (vi_rd_en),
      .rd_addr (vi_rd_addr),
      .rd_data (vi_rd_raw)
   );

   // ---------------- ports ----------------
   assign req_tready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, VERTEX_FIELD_W'(rsp_comp_ff), VERTEX_FIELD_W'(rsp_vertex_ff)};
   assign rsp_tuser  = rsp_lastc_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `SCC_ASSERT_IMPLY(a_root_empty_stack, clock, reset, state_ff == ST_ROOT, call_depth_ff == '0, "root search with frames left on the call stack")
   `SCC_ASSERT_IMPLY(a_scan_cur_live, clock, reset, state_ff == ST_SCAN, visited_ff[cur_v_ff] && on_stack_ff[cur_v_ff], "current vertex not visited or not on stack")
   `SCC_ASSERT_ALWAYS(a_depth_bound, clock, reset, call_depth_ff <= (VW+1)'(MAX_VERTICES), "call depth beyond vertex count")
   `SCC_ASSERT_IMPLY(a_emit_room, clock, reset, emit && pend_valid_ff, !rsp_valid_ff || rsp_tready, "result overwritten while stalled")

endmodule
